// File: hdl/multi_channel_debounce_reporter_macros.svh
// Assertion macros shared by the debounce reporter modules.
// Depends on nothing; included by every file that asserts.
`ifndef MULTI_CHANNEL_DEBOUNCE_REPORTER_MACROS_SVH
`define MULTI_CHANNEL_DEBOUNCE_REPORTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mcdr_pkg.sv
// Shared types and constants of the multi-channel debounce reporter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcdr_pkg;

  localparam int N_CHANNELS = 18;
  localparam int CH_W       = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;

  localparam int PIN_W      = 18;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 8;
  localparam int PERIOD_W   = 16;
  localparam int RES_CH_W   = 5;
  localparam int MAP_W      = 18;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = DEB_W'(25);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(3000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SNAPSHOT_PERIOD = CFG_IDX_W'(1);

  // Result kinds.
  localparam logic KIND_EVENT    = 1'b0;
  localparam logic KIND_SNAPSHOT = 1'b1;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic                kind;
    logic [RES_CH_W-1:0] channel;
    logic                new_level;
    logic [MAP_W-1:0]    stable_map;
    logic                last;
  } result_t;

  // What one lane reports for the sample being accepted.
  typedef struct packed {
    logic fire;         // stable level changes on this sample
    logic level;        // sampled level, the new stable level when fire is set
    logic stable_next;  // stable level after this sample
  } lane_report_t;

endpackage

// File: hdl/mcdr_lane.sv
// One debounce lane: raw level, change time and stable level of a channel.
// Depends on mcdr_pkg.
`timescale 1ns / 1ps

module mcdr_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         pin,
  input  logic [mcdr_pkg::TIME_W-1:0]  now,
  input  logic [mcdr_pkg::DEB_W-1:0]   debounce_time,
  output mcdr_pkg::lane_report_t       report
);
  import mcdr_pkg::*;

  logic              raw;
  logic              stable;
  logic [TIME_W-1:0] change_time;
  logic [TIME_W-1:0] held;
  logic              fire;

  // Elapsed time wraps modulo 2^32.
  assign held = now - change_time;
  assign fire = (pin == raw) && (pin != stable) && (held >= TIME_W'(debounce_time));

  always_ff @(posedge clk) begin
    if (rst) begin
      raw         <= 1'b1;
      stable      <= 1'b1;
      change_time <= '0;
    end else if (load) begin
      if (pin != raw) begin
        raw         <= pin;
        change_time <= now;
      end
      if (fire) begin
        stable <= pin;
      end
    end
  end

  always_comb begin
    report.fire        = fire;
    report.level       = pin;
    report.stable_next = fire ? pin : stable;
  end

endmodule

// File: hdl/mcdr_merge.sv
// Merging stage: collects lane reports, decides the snapshot and sends the results one
// per cycle in channel order while result_stall is low. Depends on mcdr_pkg and the macros.
`timescale 1ns / 1ps
`include "multi_channel_debounce_reporter_macros.svh"

module mcdr_merge (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              load,
  input  mcdr_pkg::lane_report_t [mcdr_pkg::N_CHANNELS-1:0] reports,
  input  logic [mcdr_pkg::TIME_W-1:0]                       now,
  input  logic [mcdr_pkg::PERIOD_W-1:0]                     snapshot_period,
  output logic                                              ready,
  output logic                                              result_valid,
  input  logic                                              result_stall,
  output mcdr_pkg::result_t                                 result
);
  import mcdr_pkg::*;

  // Batch of pending results for the item last accepted.
  logic [N_CHANNELS-1:0] ev_mask;
  logic [N_CHANNELS-1:0] ev_level;
  logic                  snap_pend;
  logic [MAP_W-1:0]      snap_map;
  logic [TIME_W-1:0]     snapshot_time;

  logic [N_CHANNELS-1:0] fires;
  logic [N_CHANNELS-1:0] levels;
  logic [N_CHANNELS-1:0] stable_vec;
  logic                  any_event;
  logic [TIME_W-1:0]     elapsed;
  logic                  snap;

  logic                  busy;
  logic                  out_load;
  logic [N_CHANNELS-1:0] rest;
  logic [N_CHANNELS-1:0] lowest;
  logic [CH_W-1:0]       low_idx;
  logic                  emit;
  result_t               emit_res;
  logic [N_CHANNELS-1:0] ev_mask_next;
  logic                  snap_pend_next;

  always_comb begin
    for (int i = 0; i < N_CHANNELS; i++) begin
      fires[i]      = reports[i].fire;
      levels[i]     = reports[i].level;
      stable_vec[i] = reports[i].stable_next;
    end
  end

  // An event moves the snapshot timer to now, so the elapsed time is zero then.
  assign any_event = |fires;
  assign elapsed   = now - snapshot_time;
  assign snap      = any_event ? (snapshot_period == '0)
                               : (elapsed >= TIME_W'(snapshot_period));

  assign busy     = (|ev_mask) || snap_pend;
  assign out_load = !result_valid || !result_stall;

  assign rest   = ev_mask & (ev_mask - N_CHANNELS'(1));
  assign lowest = ev_mask & ~rest;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < N_CHANNELS; i++) begin
      if (lowest[i]) begin
        low_idx = low_idx | CH_W'(i);
      end
    end
  end

  always_comb begin
    emit           = 1'b0;
    emit_res       = '0;
    ev_mask_next   = ev_mask;
    snap_pend_next = snap_pend;
    if (|ev_mask) begin
      emit               = 1'b1;
      emit_res.kind      = KIND_EVENT;
      emit_res.channel   = RES_CH_W'(low_idx);
      emit_res.new_level = |(lowest & ev_level);
      emit_res.last      = (rest == '0) && !snap_pend;
      ev_mask_next       = rest;
    end else if (snap_pend) begin
      emit                = 1'b1;
      emit_res.kind       = KIND_SNAPSHOT;
      emit_res.stable_map = snap_map;
      emit_res.last       = 1'b1;
      snap_pend_next      = 1'b0;
    end
  end

  // A new item may enter once its predecessor's last result is leaving.
  assign ready = !busy || (out_load && emit && emit_res.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_mask       <= '0;
      snap_pend     <= 1'b0;
      snapshot_time <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (load) begin
        ev_mask   <= fires;
        snap_pend <= snap;
        if (any_event || snap) begin
          snapshot_time <= now;
        end
      end else if (out_load) begin
        ev_mask   <= ev_mask_next;
        snap_pend <= snap_pend_next;
      end
      if (out_load) begin
        result_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_level <= levels;
      snap_map <= MAP_W'(stable_vec);
    end
    if (out_load) begin
      result <= emit_res;
    end
  end

  `MCDR_ASSERT_NOW(a_event_no_map, clk, rst,
    result_valid && (result.kind == KIND_EVENT), result.stable_map == '0,
    "change event carries a nonzero stable map")
  `MCDR_ASSERT_NOW(a_snapshot_last, clk, rst,
    result_valid && (result.kind == KIND_SNAPSHOT), result.last,
    "snapshot is not the final result of its item")
  `MCDR_ASSERT_NOW(a_no_overwrite, clk, rst,
    load, !busy || (out_load && emit && emit_res.last),
    "new item overwrites pending results")
  `MCDR_ASSERT_NEXT(a_drain_moves, clk, rst,
    busy && out_load && !load, result_valid,
    "pending result did not reach the output register")

endmodule

// File: hdl/multi_channel_debounce_reporter.sv
// The results of an item wait in the merging stage's pending batch before they move to the output register.
// Throughput: an item yields at most N_CHANNELS + 1 results, sent one per cycle while
// result_stall is low; the one-result-per-cycle output register sets that rate.
// The next item is taken in the cycle that the last result of the current one enters the output register.
// Reset (rst, synchronous): all levels high, change and snapshot times zero, defaults loaded.
// Top level of the multi-channel debounce reporter; depends on mcdr_pkg, mcdr_lane, mcdr_merge.
`timescale 1ns / 1ps

module multi_channel_debounce_reporter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  mcdr_pkg::sample_t                  sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output mcdr_pkg::result_t                  result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mcdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mcdr_pkg::PERIOD_W-1:0]      cfg_data
);
  import mcdr_pkg::*;

  // Configuration registers. Writes to an unknown index are dropped.
  logic [DEB_W-1:0]    debounce_time;
  logic [PERIOD_W-1:0] snapshot_period;

  logic                                  load;
  logic                                  merge_ready;
  logic [N_CHANNELS-1:0]                 pins;
  lane_report_t [N_CHANNELS-1:0]         reports;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      snapshot_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME:   debounce_time   <= DEB_W'(cfg_data);
        REG_SNAPSHOT_PERIOD: snapshot_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // An item is taken whenever the merging stage has room for its results.
  assign sample_stall = !merge_ready;
  assign load         = sample_valid && !sample_stall;

  // Channels beyond the sampled width see a constant low level.
  assign pins = N_CHANNELS'(sample.pin_levels);

  // One lane per channel. All lanes update their state in the cycle the item
  // is accepted and report whether their stable level changes.
  for (genvar g = 0; g < N_CHANNELS; g++) begin : g_lane
    mcdr_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .load          (load),
      .pin           (pins[g]),
      .now           (sample.time_ms),
      .debounce_time (debounce_time),
      .report        (reports[g])
    );
  end

  // The merging stage turns the lane reports into a batch of change events in
  // channel order plus an optional snapshot, and sends them one per cycle while result_stall is low.
  mcdr_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .load            (load),
    .reports         (reports),
    .now             (sample.time_ms),
    .snapshot_period (snapshot_period),
    .ready           (merge_ready),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result)
  );

endmodule

// File: test/multi_channel_debounce_reporter_test.sv
// Self-checking testbench for the multi-channel debounce reporter.
// Depends on mcdr_pkg and multi_channel_debounce_reporter, and through it on mcdr_lane and mcdr_merge.
`timescale 1ns / 1ps

module multi_channel_debounce_reporter_test;
  import mcdr_pkg::*;

  // Indexes outside the register map; writes to them must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  // Cycles allowed to pass after the last expected report before the block counts as idle.
  // An accepted item's results wait in the merging stage's pending batch before the output
  // register, so this margin covers an item that is still in flight and produces no report.
  localparam int SETTLE_CYCLES = 8;

  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic     sample_valid = 1'b0;
  logic     sample_stall;
  sample_t  sample = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [PERIOD_W-1:0]   cfg_data = '0;

  multi_channel_debounce_reporter u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns period: high for half, low for half.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Percent chance, per cycle, that the sender holds back an item or the receiver stalls.
  int sender_gap_pct = 37;
  int receiver_stall_pct = 37;
  int fail_count = 0;
  int quiet_cycles = 0;

  // Shadow copy of the block's registers and per-channel debounce state.
  logic [DEB_W-1:0]      model_debounce;
  logic [PERIOD_W-1:0]   model_period;
  logic [PIN_W-1:0]      model_stable;
  logic [PIN_W-1:0]      model_raw;
  logic [TIME_W-1:0]     model_edge_time [N_CHANNELS];
  logic [TIME_W-1:0]     model_snap_time;

  // Reports still owed by the block, oldest first.
  result_t pending_reports [$];

  function automatic void reset_model();
    model_debounce  = DEBOUNCE_RESET;
    model_period    = PERIOD_RESET;
    model_stable    = '1;
    model_raw       = '1;
    model_snap_time = '0;
    for (int ch = 0; ch < N_CHANNELS; ch++) begin
      model_edge_time[ch] = '0;
    end
  endfunction

  // Advances the shadow state by one sample and queues the reports it must cause.
  // Channels are walked in ascending order, so change events come out in channel order;
  // any event restarts the snapshot timer, and the snapshot test runs after all channels.
  function automatic void debounce_sample(sample_t s);
    int first_new;
    logic lvl;
    logic [TIME_W-1:0] held;
    result_t rep;
    first_new = pending_reports.size();
    for (int ch = 0; ch < N_CHANNELS; ch++) begin
      lvl = s.pin_levels[ch];
      if (lvl != model_raw[ch]) begin
        // A raw change only restarts this channel's hold timer.
        model_raw[ch] = lvl;
        model_edge_time[ch] = s.time_ms;
        continue;
      end
      if (lvl == model_stable[ch]) continue;
      held = s.time_ms - model_edge_time[ch];
      if (held < TIME_W'(model_debounce)) continue;
      model_stable[ch] = lvl;
      rep = '0;
      rep.kind = KIND_EVENT;
      rep.channel = RES_CH_W'(ch);
      rep.new_level = lvl;
      pending_reports.push_back(rep);
      model_snap_time = s.time_ms;
    end
    if (TIME_W'(s.time_ms - model_snap_time) >= TIME_W'(model_period)) begin
      model_snap_time = s.time_ms;
      rep = '0;
      rep.kind = KIND_SNAPSHOT;
      rep.stable_map = model_stable;
      pending_reports.push_back(rep);
    end
    if (pending_reports.size() > first_new) begin
      pending_reports[pending_reports.size() - 1].last = 1'b1;
    end
  endfunction

  // Receiver: stalls at random, changing only at the falling edge.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Every accepted report is matched against the oldest one still owed.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report with none expected: kind %0d channel %0d map %h",
               result.kind, result.channel, result.stable_map);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, result.kind);
          fail_count++;
        end
        if (result.channel !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, result.channel);
          fail_count++;
        end
        if (result.new_level !== want.new_level) begin
          $error("new_level: expected %0d, got %0d", want.new_level, result.new_level);
          fail_count++;
        end
        if (result.stable_map !== want.stable_map) begin
          $error("stable_map: expected %h, got %h", want.stable_map, result.stable_map);
          fail_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_channel_debounce_reporter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample, with random gaps ahead of it, and updates the shadow state once the
  // block takes it. Valid is left high afterwards, so back-to-back items never drop it;
  // the next call or a drain lowers it at a later falling edge.
  task automatic send_sample(input logic [PIN_W-1:0] pins, input logic [TIME_W-1:0] stamp);
    sample_t s;
    s.pin_levels = pins;
    s.time_ms = stamp;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    debounce_sample(s);
  endtask

  // Stops offering items and waits until every owed report has come out, plus the
  // block's latency, so that a configuration write lands on an idle block.
  task automatic drain_wait();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // Only the low byte reaches the debounce register; unmapped indexes change nothing.
    if (idx == REG_DEBOUNCE_TIME) begin
      model_debounce = data[DEB_W-1:0];
    end else if (idx == REG_SNAPSHOT_PERIOD) begin
      model_period = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset defaults: a quiet line reports nothing until the default period runs out.
  task automatic test_reset_defaults();
    send_sample('1, 32'd0);
    send_sample('1, 32'd2999);
    send_sample('1, 32'd3000);
  endtask

  // Whole-word level changes, the hold threshold on both sides, and a hold that spans
  // the wrap of the millisecond counter.
  task automatic test_level_extremes();
    send_sample('0, 32'd3010);
    send_sample('0, 32'd3034);
    send_sample('0, 32'd3035);
    send_sample(18'h2AAAA, 32'd3036);
    send_sample(18'h2AAAA, 32'd3061);
    send_sample(18'h15555, 32'hFFFF_FFF0);
    send_sample(18'h15555, 32'h0000_0010);
  endtask

  // Register extremes: zero debounce with zero period, ignored writes to unmapped
  // indexes, then the largest debounce time and snapshot period.
  task automatic test_register_extremes();
    drain_wait();
    write_reg(REG_DEBOUNCE_TIME, 16'hFF00);
    write_reg(REG_SNAPSHOT_PERIOD, 16'h0000);
    // With zero debounce the first sample only records the change, the second commits it,
    // and a zero period puts a snapshot behind every sample, events or not.
    send_sample('1, 32'd100);
    send_sample('1, 32'd100);
    drain_wait();
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'hFFFF);
    send_sample('1, 32'd101);
    drain_wait();
    write_reg(REG_DEBOUNCE_TIME, 16'h00FF);
    write_reg(REG_SNAPSHOT_PERIOD, 16'hFFFF);
    send_sample('0, 32'd200);
    send_sample('0, 32'd454);
    send_sample('0, 32'd455);
    send_sample('0, 32'd455 + 32'd65534);
    send_sample('0, 32'd455 + 32'd65535);
  endtask

  // Random traffic over several register settings. Most samples follow a live signal:
  // time creeps forward and a few channels bounce now and then, so levels settle and
  // events and snapshots come out. The rest are arbitrary pin words and time jumps.
  task automatic test_random_traffic();
    logic [PIN_W-1:0] pins;
    logic [TIME_W-1:0] now;
    int deb;
    int idx;
    for (int phase = 0; phase < 4; phase++) begin
      drain_wait();
      // The second phase runs with neither side idling.
      sender_gap_pct = (phase == 1) ? 0 : 37;
      receiver_stall_pct = (phase == 1) ? 0 : 37;
      deb = $urandom_range(0, (phase == 3) ? 255 : 30);
      write_reg(REG_DEBOUNCE_TIME, {8'($urandom), 8'(deb)});
      write_reg(REG_SNAPSHOT_PERIOD,
                16'((phase == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 400)));
      pins = model_raw;
      now = $urandom;
      for (int n = 0; n < 48; n++) begin
        // Halfway through, hold the sender until the block has caught up.
        if (n == 24) drain_wait();
        if ($urandom_range(0, 99) < 80) begin
          if ($urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 3)) begin
              idx = $urandom_range(0, N_CHANNELS - 1);
              pins[idx] = ~pins[idx];
            end
          end
          now = now + TIME_W'($urandom_range(0, deb / 3 + 3));
        end else begin
          pins = PIN_W'($urandom);
          now = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom)
                                            : now + TIME_W'($urandom_range(0, 5000));
        end
        send_sample(pins, now);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_level_extremes();
    test_register_extremes();
    test_random_traffic();

    drain_wait();
    if (fail_count == 0) begin
      $display("multi_channel_debounce_reporter regression: pass");
    end else begin
      $display("multi_channel_debounce_reporter regression: fail");
    end
    $finish;
  end

endmodule
